FILE: rtl/i2ctrf_pkg.sv
// Package: opcodes, phase and stop codes, shared types and helpers of the I2C target register file
`default_nettype none
package i2ctrf_pkg;

    localparam int I2CTRF_REG_COUNT = 16;
    localparam logic [7:0] TXN_LIMIT_RST = 8'd32;
    localparam logic [7:0] COUNT_MAX = 8'hff;

    localparam logic [3:0] OP_ADDR_WRITE = 4'd0;
    localparam logic [3:0] OP_ADDR_READ  = 4'd1;
    localparam logic [3:0] OP_BYTE_RX    = 4'd2;
    localparam logic [3:0] OP_MASTER_ACK = 4'd3;
    localparam logic [3:0] OP_MASTER_NAK = 4'd4;
    localparam logic [3:0] OP_STOP       = 4'd5;
    localparam logic [3:0] OP_BUS_ERROR  = 4'd6;
    localparam logic [3:0] OP_LOC_WRITE  = 4'd7;
    localparam logic [3:0] OP_LOC_READ   = 4'd8;
    localparam logic [3:0] OP_CLR_STOP   = 4'd9;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_AWAIT_PTR = 3'd1;
    localparam logic [2:0] PH_PTR_SET   = 3'd2;
    localparam logic [2:0] PH_READING   = 3'd3;
    localparam logic [2:0] PH_WRITING   = 3'd4;

    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_PTR_ONLY = 3'd1;
    localparam logic [2:0] ST_RD_DONE  = 3'd2;
    localparam logic [2:0] ST_WR_DONE  = 3'd3;
    localparam logic [2:0] ST_INVALID  = 3'd4;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_req_t;

    typedef struct packed {
        logic       send_sel;
        logic       send_valid;
        logic       ack_out;
        logic [2:0] stop_status;
        logic [2:0] bus_phase;
        logic [3:0] pointer_now;
        logic [3:0] first_register;
        logic [7:0] data_count;
    } res_t;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        sat_inc = (v == COUNT_MAX) ? v : v + 8'd1;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/i2ctrf_if.sv
// Interfaces: event, result and configuration channels of the I2C target register file
`default_nettype none
interface i2ctrf_evt_if;
    logic       valid;
    logic       ready;
    logic [3:0] opcode;
    logic [7:0] bus_byte;
    logic [3:0] local_index;
    logic [7:0] local_data;
    modport source (output valid, opcode, bus_byte, local_index, local_data, input ready);
    modport sink (input valid, opcode, bus_byte, local_index, local_data, output ready);
endinterface

interface i2ctrf_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] send_data;
    logic       send_valid;
    logic       ack_out;
    logic [2:0] stop_status;
    logic [2:0] bus_phase;
    logic [3:0] pointer_now;
    logic [3:0] first_register;
    logic [7:0] data_count;
    modport source (output valid, send_data, send_valid, ack_out, stop_status, bus_phase,
                    pointer_now, first_register, data_count, input ready);
    modport sink (input valid, send_data, send_valid, ack_out, stop_status, bus_phase,
                  pointer_now, first_register, data_count, output ready);
endinterface

interface i2ctrf_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/i2ctrf_regmem.sv
// Register store: synchronous one-read one-write byte memory with per-entry valid bits
`default_nettype none
module i2ctrf_regmem
    import i2ctrf_pkg::*;
#(
    parameter int REG_COUNT = I2CTRF_REG_COUNT,
    localparam int PW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mem_req_t             req,
    input  wire logic [PW-1:0]        rd_addr,
    input  wire logic [PW-1:0]        wr_addr,
    input  wire logic [7:0]           wr_data,
    output logic [7:0]                rd_data
);
    logic [7:0]           mem [REG_COUNT];
    logic [REG_COUNT-1:0] vld_reg;
    logic [7:0]           rd_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_reg : 8'd0;

endmodule
`default_nettype wire

FILE: rtl/i2ctrf_ctrl.sv
// Transaction control: pointer, phase, stop code and counters, memory request per word
`default_nettype none
module i2ctrf_ctrl
    import i2ctrf_pkg::*;
#(
    parameter int REG_COUNT = I2CTRF_REG_COUNT,
    localparam int PW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [3:0]    opcode,
    input  wire logic [7:0]    bus_byte,
    input  wire logic [3:0]    local_index,
    input  wire logic [7:0]    local_data,
    input  wire logic [7:0]    txn_limit,
    output mem_req_t           req,
    output logic [PW-1:0]      rd_addr,
    output logic [PW-1:0]      wr_addr,
    output logic [7:0]         wr_data,
    output res_t               res
);
    logic [PW-1:0] ptr_reg, ptr_next;
    logic [PW-1:0] start_reg, start_next;
    logic [2:0]    phase_reg, phase_next;
    logic [2:0]    stop_reg, stop_next;
    logic [7:0]    moved_reg, moved_next;
    logic [7:0]    limit_reg, limit_next;
    logic [PW:0]   ptr_inc;
    logic [PW-1:0] ptr_adv;
    logic [7:0]    li_ext;
    logic          li_ok;
    logic          bb_ok;
    logic [7:0]    ptr_ext;
    logic [7:0]    start_ext;
    logic          wr_en;
    logic          rd_en;
    logic          send_sel;
    logic          send_valid;
    logic          ack;

    assign ptr_inc = {1'b0, ptr_reg} + (PW+1)'(1);
    assign ptr_adv = (ptr_inc >= (PW+1)'(REG_COUNT)) ? '0 : ptr_inc[PW-1:0];
    assign li_ext  = {4'd0, local_index};
    assign li_ok   = ({1'b0, li_ext} < 9'(REG_COUNT));
    assign bb_ok   = ({1'b0, bus_byte} < 9'(REG_COUNT));

    always_comb
    begin
        ptr_next   = ptr_reg;
        start_next = start_reg;
        phase_next = phase_reg;
        stop_next  = stop_reg;
        moved_next = moved_reg;
        limit_next = limit_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        send_sel   = 1'b0;
        send_valid = 1'b0;
        ack        = 1'b0;
        rd_addr    = ptr_reg;
        wr_addr    = ptr_reg;
        wr_data    = bus_byte;
        unique case (opcode)
            OP_ADDR_WRITE:
            begin
                stop_next  = ST_NONE;
                moved_next = 8'd0;
                limit_next = 8'd0;
                ack        = 1'b1;
                if (phase_reg == PH_IDLE)
                begin
                    phase_next = PH_AWAIT_PTR;
                end
            end
            OP_ADDR_READ:
            begin
                stop_next  = ST_NONE;
                moved_next = 8'd1;
                limit_next = 8'd0;
                ptr_next   = ptr_adv;
                phase_next = PH_READING;
                rd_en      = 1'b1;
                send_sel   = 1'b1;
                send_valid = 1'b1;
                ack        = 1'b1;
            end
            OP_BYTE_RX:
            begin
                if (phase_reg == PH_AWAIT_PTR)
                begin
                    ptr_next   = bb_ok ? bus_byte[PW-1:0] : '0;
                    start_next = bb_ok ? bus_byte[PW-1:0] : '0;
                    phase_next = PH_PTR_SET;
                end
                else
                begin
                    wr_en      = 1'b1;
                    moved_next = sat_inc(moved_reg);
                    ptr_next   = ptr_adv;
                    phase_next = PH_WRITING;
                end
                limit_next = sat_inc(limit_reg);
                ack        = (limit_next <= txn_limit);
            end
            OP_MASTER_ACK:
            begin
                moved_next = sat_inc(moved_reg);
                limit_next = sat_inc(limit_reg);
                ptr_next   = ptr_adv;
                phase_next = PH_READING;
                rd_en      = 1'b1;
                send_sel   = 1'b1;
                send_valid = 1'b1;
                ack        = 1'b1;
            end
            OP_STOP:
            begin
                priority if (phase_reg == PH_PTR_SET)
                begin
                    stop_next = ST_PTR_ONLY;
                end
                else if (phase_reg == PH_READING)
                begin
                    stop_next = ST_RD_DONE;
                end
                else if (phase_reg == PH_WRITING)
                begin
                    stop_next = ST_WR_DONE;
                end
                else
                begin
                    stop_next = ST_INVALID;
                end
                phase_next = PH_IDLE;
            end
            OP_BUS_ERROR:
            begin
                start_next = '0;
                moved_next = 8'd0;
                ptr_next   = '0;
                stop_next  = ST_NONE;
                phase_next = PH_IDLE;
            end
            OP_LOC_WRITE:
            begin
                wr_en   = li_ok;
                wr_addr = li_ext[PW-1:0];
                wr_data = local_data;
            end
            OP_LOC_READ:
            begin
                rd_en      = li_ok;
                rd_addr    = li_ext[PW-1:0];
                send_sel   = li_ok;
                send_valid = 1'b1;
            end
            OP_CLR_STOP:
            begin
                stop_next = ST_NONE;
            end
            default:
            begin
                // master NACK and unused codes leave the state alone
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            start_reg <= '0;
            phase_reg <= PH_IDLE;
            stop_reg  <= ST_NONE;
            moved_reg <= 8'd0;
            limit_reg <= 8'd0;
        end
        else if (accept)
        begin
            ptr_reg   <= ptr_next;
            start_reg <= start_next;
            phase_reg <= phase_next;
            stop_reg  <= stop_next;
            moved_reg <= moved_next;
            limit_reg <= limit_next;
        end
    end

    assign ptr_ext   = 8'(ptr_next);
    assign start_ext = 8'(start_next);

    assign req.wr_en = accept && wr_en;
    assign req.rd_en = accept && rd_en;

    assign res.send_sel       = send_sel;
    assign res.send_valid     = send_valid;
    assign res.ack_out        = ack;
    assign res.stop_status    = stop_next;
    assign res.bus_phase      = phase_next;
    assign res.pointer_now    = ptr_ext[3:0];
    assign res.first_register = start_ext[3:0];
    assign res.data_count     = moved_next;

endmodule
`default_nettype wire

FILE: rtl/i2c_target_register_file_top.sv
// Top level: I2C target register file with event, result and configuration channels
//
// Takes one decoded bus event or local access word per clock and returns one result word
// for each. The control state updates in the cycle a word is accepted, and the register
// store, a synchronous memory with one read and one write port, reads its byte at the
// accept edge that loads the output register, so throughput is one word per cycle while
// the result side takes words. A write in one cycle is seen by a read in the next, since
// both go through the single memory at the accept edge. The result register stalls the
// event side only while a word waits in it and the result side holds ready low.
// The transaction byte limit is written through the configuration channel, which is always
// ready.
`default_nettype none
module i2c_target_register_file_top
    import i2ctrf_pkg::*;
#(
    parameter int REG_COUNT = I2CTRF_REG_COUNT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    i2ctrf_evt_if.sink    evt,
    i2ctrf_res_if.source  res,
    i2ctrf_cfg_if.sink    cfg
);
    localparam int PW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    logic          accept;
    logic [7:0]    max_trans_reg;
    logic          out_vld_reg, out_vld_next;
    res_t          res_reg;
    res_t          res_now;
    mem_req_t      mem_req;
    logic [PW-1:0] rd_addr;
    logic [PW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [7:0]    rd_data;

    assign cfg.ready = 1'b1;
    assign evt.ready = !out_vld_reg || res.ready;
    assign accept    = evt.valid && evt.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_trans_reg <= TXN_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            max_trans_reg <= cfg.data;
        end
    end

    i2ctrf_ctrl #(
        .REG_COUNT (REG_COUNT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .opcode      (evt.opcode),
        .bus_byte    (evt.bus_byte),
        .local_index (evt.local_index),
        .local_data  (evt.local_data),
        .txn_limit   (max_trans_reg),
        .req         (mem_req),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .res         (res_now)
    );

    i2ctrf_regmem #(
        .REG_COUNT (REG_COUNT)
    ) u_regmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    always_comb
    begin
        out_vld_next = out_vld_reg;
        priority if (accept)
        begin
            out_vld_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_now;
        end
    end

    assign res.valid          = out_vld_reg;
    assign res.send_data      = res_reg.send_sel ? rd_data : 8'd0;
    assign res.send_valid     = res_reg.send_valid;
    assign res.ack_out        = res_reg.ack_out;
    assign res.stop_status    = res_reg.stop_status;
    assign res.bus_phase      = res_reg.bus_phase;
    assign res.pointer_now    = res_reg.pointer_now;
    assign res.first_register = res_reg.first_register;
    assign res.data_count     = res_reg.data_count;

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !res.ready |-> !evt.ready)
        else $error("event accepted while result word is held");

    a_read_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (evt.opcode == OP_ADDR_READ || evt.opcode == OP_MASTER_ACK)
        |=> res.valid && res.send_valid && res.bus_phase == PH_READING)
        else $error("bus read did not produce a byte");

    a_quiet_data: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.send_valid |-> res.send_data == 8'd0)
        else $error("send_data nonzero without send_valid");

    a_stop_idles: assert property (@(posedge clk) disable iff (!rst_n)
        accept && evt.opcode == OP_STOP |=> res.bus_phase == PH_IDLE
        && res.stop_status != ST_NONE)
        else $error("stop did not close the transaction");

endmodule
`default_nettype wire
